// ===== design/ira_pkg.sv =====
// ----------------------------------------------------------------------------
// ira_pkg
// Shared constants, types and the digit-to-ASCII mapping for the radix
// conversion core.
// ----------------------------------------------------------------------------
`default_nettype none

package ira_pkg;

	localparam int MAX_DIGITS = 64;
	localparam int VALUE_W    = 64;
	localparam int BASE_W     = 5;
	localparam int DIGIT_W    = 4;
	localparam int CHAR_W     = 7;
	localparam int ADDR_W     = $clog2(MAX_DIGITS);
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
	localparam int STEP_W     = $clog2(VALUE_W);

	localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_RD,
		ST_LD
	} ira_state_t;

	typedef struct packed {
		logic load;
		logic zero_digit;
		logic div_start;
		logic div_step;
		logic emit_init;
		logic emit_rd;
		logic emit_ld;
	} ira_cmd_t;

	typedef struct packed {
		logic q_zero;
		logic cnt_zero;
		logic cnt_full;
		logic step_last;
		logic emit_last;
		logic out_free;
	} ira_status_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
		input logic upper);
		logic [CHAR_W-1:0] d_ext;
		d_ext = CHAR_W'(d);
		if (d < DIGIT_W'(10)) begin
			return CHAR_ZERO + d_ext;
		end else if (upper) begin
			return CHAR_UPPER + d_ext - CHAR_W'(10);
		end else begin
			return CHAR_LOWER + d_ext - CHAR_W'(10);
		end
	endfunction

endpackage

`default_nettype wire

// ===== design/ira_ram.sv =====
// ----------------------------------------------------------------------------
// ira_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/ira_datapath.sv =====
// ----------------------------------------------------------------------------
// ira_datapath
// Operand preparation, bit-serial divider by the base, digit store and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire ira_pkg::ira_cmd_t               cmd,
	output ira_pkg::ira_status_t                 status,
	input  wire logic [ira_pkg::VALUE_W-1:0]     value,
	input  wire logic [ira_pkg::BASE_W-1:0]      base,
	input  wire logic                            signed_mode,
	input  wire logic                            upper_case,
	input  wire logic                            narrow_16,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [ira_pkg::CHAR_W-1:0]      ascii_char,
	output logic                                 leading_minus,
	output logic                                 last
);

	logic [ira_pkg::VALUE_W-1:0] q_q;
	logic [ira_pkg::DIGIT_W-1:0] r_q;
	logic [ira_pkg::BASE_W-1:0]  base_q;
	logic                        upper_q;
	logic                        neg_q;
	logic [ira_pkg::CNT_W-1:0]   n_q;
	logic [ira_pkg::STEP_W-1:0]  step_q;
	logic [ira_pkg::ADDR_W-1:0]  e_q;
	logic                        first_q;
	logic                        out_valid_q;
	logic [ira_pkg::CHAR_W-1:0]  char_q;
	logic                        minus_q;
	logic                        last_q;

	logic [ira_pkg::VALUE_W-1:0] v_ext;
	logic                        v_neg;
	logic [ira_pkg::VALUE_W-1:0] v_mag;
	logic [ira_pkg::BASE_W-1:0]  base_sat;
	logic [ira_pkg::BASE_W-1:0]  trial;
	logic                        fits;
	logic [ira_pkg::DIGIT_W-1:0] r_nxt;
	logic                        step_last;

	logic                        ram_we;
	logic [ira_pkg::ADDR_W-1:0]  ram_waddr;
	logic [ira_pkg::DIGIT_W-1:0] ram_wdata;
	logic [ira_pkg::DIGIT_W-1:0] ram_rdata;

	// operand conditioning
	always_comb begin
		if (narrow_16) begin
			v_ext = {{(ira_pkg::VALUE_W-16){signed_mode & value[15]}}, value[15:0]};
		end else begin
			v_ext = value;
		end
		v_neg = signed_mode & v_ext[ira_pkg::VALUE_W-1];
		v_mag = v_neg ? (~v_ext + ira_pkg::VALUE_W'(1)) : v_ext;
		if (base < ira_pkg::BASE_MIN) begin
			base_sat = ira_pkg::BASE_MIN;
		end else if (base > ira_pkg::BASE_MAX) begin
			base_sat = ira_pkg::BASE_MAX;
		end else begin
			base_sat = base;
		end
	end

	// one restoring division step; the partial remainder stays below the base
	assign trial     = {r_q, q_q[ira_pkg::VALUE_W-1]};
	assign fits      = trial >= base_q;
	assign r_nxt     = fits ? ira_pkg::DIGIT_W'(trial - base_q)
		: trial[ira_pkg::DIGIT_W-1:0];
	assign step_last = step_q == ira_pkg::STEP_W'(ira_pkg::VALUE_W - 1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = n_q[ira_pkg::ADDR_W-1:0];
		ram_wdata = r_nxt[ira_pkg::DIGIT_W-1:0];
		if (cmd.zero_digit) begin
			ram_we    = 1'b1;
			ram_waddr = '0;
			ram_wdata = '0;
		end else if (cmd.div_step && step_last) begin
			ram_we = 1'b1;
		end
	end

	ira_ram #(
		.WIDTH(ira_pkg::DIGIT_W),
		.DEPTH(ira_pkg::MAX_DIGITS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.emit_rd),
		.raddr(e_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q  <= base_sat;
			upper_q <= upper_case;
			neg_q   <= v_neg;
		end
		if (cmd.div_start) begin
			r_q <= '0;
		end else if (cmd.div_step) begin
			r_q <= r_nxt[ira_pkg::DIGIT_W-1:0];
		end
		if (cmd.emit_ld) begin
			char_q  <= ira_pkg::digit_char(ram_rdata, upper_q);
			minus_q <= first_q & neg_q;
			last_q  <= e_q == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q         <= '0;
			n_q         <= '0;
			step_q      <= '0;
			e_q         <= '0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				q_q <= v_mag;
				n_q <= '0;
			end else if (cmd.zero_digit) begin
				n_q <= ira_pkg::CNT_W'(1);
			end else if (cmd.div_step) begin
				q_q <= {q_q[ira_pkg::VALUE_W-2:0], fits};
				if (step_last) begin
					n_q <= n_q + ira_pkg::CNT_W'(1);
				end
			end
			if (cmd.div_start) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + ira_pkg::STEP_W'(1);
			end
			if (cmd.emit_init) begin
				e_q     <= ira_pkg::ADDR_W'(n_q - ira_pkg::CNT_W'(1));
				first_q <= 1'b1;
			end else if (cmd.emit_ld) begin
				e_q     <= e_q - ira_pkg::ADDR_W'(1);
				first_q <= 1'b0;
			end
			if (cmd.emit_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.q_zero    = q_q == '0;
	assign status.cnt_zero  = n_q == '0;
	assign status.cnt_full  = n_q == ira_pkg::CNT_W'(ira_pkg::MAX_DIGITS);
	assign status.step_last = step_last;
	assign status.emit_last = e_q == '0;
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign ascii_char    = char_q;
	assign leading_minus = minus_q;
	assign last          = last_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= ira_pkg::CNT_W'(ira_pkg::MAX_DIGITS))
		else $error("digit count beyond store depth");

	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> ({1'b0, r_q} < base_q))
		else $error("partial remainder not below base");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_ld |-> (!out_valid_q || out_ready))
		else $error("output register overwritten before transfer");

	a_zero_only_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.zero_digit |-> (n_q == '0 && q_q == '0))
		else $error("zero digit written into non-empty store");
`endif

endmodule

`default_nettype wire

// ===== design/ira_ctrl.sv =====
// ----------------------------------------------------------------------------
// ira_ctrl
// Sequencer: operand load, digit division loop and digit emission.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire ira_pkg::ira_status_t status,
	output ira_pkg::ira_cmd_t         cmd
);

	ira_pkg::ira_state_t state_q;
	ira_pkg::ira_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ira_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ira_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ira_pkg::ST_CHECK;
				end
			end
			ira_pkg::ST_CHECK: begin
				if (status.q_zero && status.cnt_zero) begin
					cmd.zero_digit = 1'b1;
				end else if (status.q_zero || status.cnt_full) begin
					cmd.emit_init = 1'b1;
					state_nxt     = ira_pkg::ST_RD;
				end else begin
					cmd.div_start = 1'b1;
					state_nxt     = ira_pkg::ST_DIV;
				end
			end
			ira_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.step_last) begin
					state_nxt = ira_pkg::ST_CHECK;
				end
			end
			ira_pkg::ST_RD: begin
				cmd.emit_rd = 1'b1;
				state_nxt   = ira_pkg::ST_LD;
			end
			ira_pkg::ST_LD: begin
				if (status.out_free) begin
					cmd.emit_ld = 1'b1;
					state_nxt   = status.emit_last ? ira_pkg::ST_IDLE : ira_pkg::ST_RD;
				end
			end
			default: begin
				state_nxt = ira_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/integer_to_radix_ascii_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_core
// Converts a 64-bit integer to ASCII digits in a radix from 2 to 16.
// ----------------------------------------------------------------------------
// One operand is converted at a time. Each digit comes from a bit-serial
// restoring divider by the base, which shifts through every quotient bit
// and is followed by a check state. Digits then leave most significant
// first through the digit RAM's registered read when the sink is ready. A
// new operand is taken as soon as the last digit sits in the output
// register. The first digit of a negative signed operand carries
// leading_minus; the final digit carries last.
`default_nettype none

module integer_to_radix_ascii_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [ira_pkg::VALUE_W-1:0] value,
	input  wire logic [ira_pkg::BASE_W-1:0]  base,
	input  wire logic                        signed_mode,
	input  wire logic                        upper_case,
	input  wire logic                        narrow_16,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [ira_pkg::CHAR_W-1:0]  ascii_char,
	output logic                             leading_minus,
	output logic                             last
);

	ira_pkg::ira_cmd_t    cmd;
	ira_pkg::ira_status_t status;

	ira_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	ira_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.value        (value),
		.base         (base),
		.signed_mode  (signed_mode),
		.upper_case   (upper_case),
		.narrow_16    (narrow_16),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ascii_char   (ascii_char),
		.leading_minus(leading_minus),
		.last         (last)
	);

endmodule

`default_nettype wire
